/* src/lpr_pkg.sv */
// shared constants for the line pixel rasterizer
package lpr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COLOR_BITS     = 16;

endpackage

/* src/line_pixel_rasterizer_unit.sv */
// line pixel rasterizer: line command in, pixel stream out
//
//  channel  | direction | tdata (lsb first)                        | tlast
//  s_axis   | in        | x_start, y_start, x_end, y_end, color    | -
//  m_axis   | out       | pixel_x, pixel_y, pixel_color            | last_pixel
//
//  a command is accepted, then set up, then streamed out as pixels:
//  max(|dx|,|dy|)+1 pixels for a slanted line, |delta| for a row or column line,
//  produced by the single error-accumulator step unit, one pixel per cycle unless
//  m_axis_tready is low
//  a zero-length line returns to idle after set-up with no transaction
//  s_axis_tready is high only when idle; m_axis_tready low holds the step unit
//  rst_n clears the sequencer and the output valid
module line_pixel_rasterizer_unit #(
    parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // x_start, y_start, x_end, y_end, line_color
    input  logic [((4*COORD_BITS+lpr_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [((2*COORD_BITS+lpr_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import lpr_pkg::*;

    localparam int W        = COORD_BITS;
    localparam int OUT_BITS = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
    localparam int PAD_BITS = OUT_BITS - (2*W + COLOR_BITS);

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} state_t;

    state_t              state_reg, state_next;
    logic [W-1:0]        xs_reg, xs_next, ys_reg, ys_next;
    logic [W-1:0]        xe_reg, xe_next, ye_reg, ye_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic [W-1:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic [W-1:0]        dx_reg, dx_next, dy_reg, dy_next, dist_reg, dist_next;
    logic [W:0]          ex_reg, ex_next, ey_reg, ey_next;
    logic                negx_reg, negx_next, negy_reg, negy_next;
    logic [W:0]          rem_reg, rem_next;
    logic                ovalid_reg, ovalid_next, olast_reg, olast_next;
    logic [W-1:0]        ox_reg, ox_next, oy_reg, oy_next;
    logic [COLOR_BITS-1:0] ocolor_reg, ocolor_next;

    logic [W-1:0] dx_abs, dy_abs, x_lo, y_lo, dmax;
    logic [W:0]   ex_sum, ey_sum;
    logic         out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, ocolor_reg, oy_reg, ox_reg};
    assign out_free      = !ovalid_reg || m_axis_tready;

    assign dx_abs = (xe_reg >= xs_reg) ? xe_reg - xs_reg : xs_reg - xe_reg;
    assign dy_abs = (ye_reg >= ys_reg) ? ye_reg - ys_reg : ys_reg - ye_reg;
    assign x_lo   = (xe_reg < xs_reg) ? xe_reg : xs_reg;
    assign y_lo   = (ye_reg < ys_reg) ? ye_reg : ys_reg;
    assign dmax   = (dx_abs > dy_abs) ? dx_abs : dy_abs;
    assign ex_sum = ex_reg + {1'b0, dx_reg};
    assign ey_sum = ey_reg + {1'b0, dy_reg};

    always_comb
    begin
        state_next  = state_reg;
        xs_next     = xs_reg;
        ys_next     = ys_reg;
        xe_next     = xe_reg;
        ye_next     = ye_reg;
        color_next  = color_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dist_next   = dist_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        negx_next   = negx_reg;
        negy_next   = negy_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        olast_next  = olast_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ocolor_next = ocolor_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    xs_next    = s_axis_tdata[W-1:0];
                    ys_next    = s_axis_tdata[2*W-1:W];
                    xe_next    = s_axis_tdata[3*W-1:2*W];
                    ye_next    = s_axis_tdata[4*W-1:3*W];
                    color_next = s_axis_tdata[4*W+COLOR_BITS-1:4*W];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // row and column lines: forced step on the major axis via a unit seed
                priority if (ys_reg == ye_reg)
                begin
                    cx_next   = x_lo;
                    cy_next   = ys_reg;
                    dx_next   = dx_abs;
                    dy_next   = '0;
                    dist_next = dx_abs;
                    ex_next   = (W+1)'(1);
                    ey_next   = '0;
                    negx_next = 1'b0;
                    negy_next = 1'b0;
                    rem_next  = {1'b0, dx_abs};
                end
                else if (xs_reg == xe_reg)
                begin
                    cx_next   = xs_reg;
                    cy_next   = y_lo;
                    dx_next   = '0;
                    dy_next   = dy_abs;
                    dist_next = dy_abs;
                    ex_next   = '0;
                    ey_next   = (W+1)'(1);
                    negx_next = 1'b0;
                    negy_next = 1'b0;
                    rem_next  = {1'b0, dy_abs};
                end
                else
                begin
                    cx_next   = xs_reg;
                    cy_next   = ys_reg;
                    dx_next   = dx_abs;
                    dy_next   = dy_abs;
                    dist_next = dmax;
                    ex_next   = '0;
                    ey_next   = '0;
                    negx_next = xe_reg < xs_reg;
                    negy_next = ye_reg < ys_reg;
                    rem_next  = {1'b0, dmax} + (W+1)'(1);
                end
                state_next = (rem_next == '0) ? ST_IDLE : ST_RUN;
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = cx_reg;
                    oy_next     = cy_reg;
                    ocolor_next = color_reg;
                    olast_next  = (rem_reg == (W+1)'(1));
                    rem_next    = rem_reg - (W+1)'(1);
                    ex_next     = ex_sum;
                    ey_next     = ey_sum;
                    if (ex_sum > {1'b0, dist_reg})
                    begin
                        ex_next = ex_sum - {1'b0, dist_reg};
                        cx_next = negx_reg ? cx_reg - W'(1) : cx_reg + W'(1);
                    end
                    if (ey_sum > {1'b0, dist_reg})
                    begin
                        ey_next = ey_sum - {1'b0, dist_reg};
                        cy_next = negy_reg ? cy_reg - W'(1) : cy_reg + W'(1);
                    end
                    if (rem_reg == (W+1)'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            xs_reg     <= '0;
            ys_reg     <= '0;
            xe_reg     <= '0;
            ye_reg     <= '0;
            color_reg  <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            dist_reg   <= '0;
            ex_reg     <= '0;
            ey_reg     <= '0;
            negx_reg   <= 1'b0;
            negy_reg   <= 1'b0;
            rem_reg    <= '0;
            olast_reg  <= 1'b0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            ocolor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            xs_reg     <= xs_next;
            ys_reg     <= ys_next;
            xe_reg     <= xe_next;
            ye_reg     <= ye_next;
            color_reg  <= color_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dist_reg   <= dist_next;
            ex_reg     <= ex_next;
            ey_reg     <= ey_next;
            negx_reg   <= negx_next;
            negy_reg   <= negy_next;
            rem_reg    <= rem_next;
            olast_reg  <= olast_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            ocolor_reg <= ocolor_next;
        end
    end

endmodule
